[rtl/core/assert_macros.svh]
// Assertion macros for the order book RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/core/ptob_pkg.sv]
// Package for the price-time order book: sizes, codes and word types.
// No dependencies.
`default_nettype none
package ptob_pkg;
	localparam int ORDER_SLOTS  = 256;
	localparam int PRICE_LEVELS = 64;
	localparam int PRICE_BITS   = 16;
	localparam int ID_BITS      = $clog2(ORDER_SLOTS);
	localparam int LINK_BITS    = ID_BITS + 1;
	localparam int LVL_BITS     = $clog2(PRICE_LEVELS);
	localparam int QDEPTH       = 2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_POP    = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_INUSE   = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  order_id;
		logic [15:0] order_price;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] best_price;
		logic [7:0]  best_order_id;
		logic        book_empty;
	} out_word_t;

	// Classified command passed from front to back.
	typedef struct packed {
		cmd_t                  cmd;
		logic [ID_BITS-1:0]    id;
		logic [PRICE_BITS-1:0] price;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_WAIT,
		B_EXEC,
		B_FIX,
		B_DONE
	} bstate_t;
endpackage
`default_nettype wire

[rtl/core/ptob_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ptob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/ptob_front.sv]
// Front end: takes commands, classifies them and queues them for the back end.
// Depends on ptob_pkg.
`default_nettype none
module ptob_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire ptob_pkg::in_word_t in_word,
	output logic                 busy,
	output logic                 job_valid,
	output ptob_pkg::job_t       job,
	input  wire logic            job_take
);
	ptob_pkg::job_t            q_q [ptob_pkg::QDEPTH];
	logic [1:0]                cnt_q;
	logic                      rd_q, wr_q;
	ptob_pkg::job_t            nj;
	logic                      push;

	assign busy      = (cnt_q == 2'(ptob_pkg::QDEPTH));
	assign push      = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_q];

	// Classify the incoming word
	always_comb begin
		nj.cmd    = ptob_pkg::cmd_t'(in_word.command);
		nj.id     = in_word.order_id[ptob_pkg::ID_BITS-1:0];
		nj.price  = in_word.order_price[ptob_pkg::PRICE_BITS-1:0];
	end

	// Hold the queue words
	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (job_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_take);
		end
	end
endmodule
`default_nettype wire

[rtl/core/ptob_back.sv]
// Back end: level table in registers, order links in RAM; runs one job at a time.
// Depends on ptob_pkg and ptob_ram.
`default_nettype none
module ptob_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              book_side,
	input  wire logic              job_valid,
	input  wire ptob_pkg::job_t    job,
	output logic                   job_take,
	output logic                   res_valid,
	output ptob_pkg::out_word_t    res
);
	localparam int IB = ptob_pkg::ID_BITS;
	localparam int LB = ptob_pkg::LINK_BITS;
	localparam int VB = ptob_pkg::LVL_BITS;
	localparam int PB = ptob_pkg::PRICE_BITS;
	localparam int NL = ptob_pkg::PRICE_LEVELS;
	localparam logic [LB-1:0] NONE = LB'(ptob_pkg::ORDER_SLOTS);

	ptob_pkg::bstate_t st_q, st_d;
	ptob_pkg::job_t    j_q;

	logic [ptob_pkg::ORDER_SLOTS-1:0] ovalid_q;
	logic [NL-1:0]   lvalid_q;
	logic [PB-1:0]   lprice_q [NL];
	logic [IB-1:0]   lhead_q  [NL];
	logic [IB-1:0]   ltail_q  [NL];

	// Order RAM: {price, prev, next}
	localparam int OW = PB + 2 * LB;
	logic          o_we;
	logic [IB-1:0] o_waddr, o_raddr;
	logic [OW-1:0] o_wdata, o_rdata;
	ptob_ram #(.WIDTH(OW), .DEPTH(ptob_pkg::ORDER_SLOTS)) u_ord (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	// Per-step scratch registers
	logic [PB-1:0] cur_price_q;
	logic [LB-1:0] prv_q, nxt_q;
	logic [IB-1:0] tgt_q;
	logic [VB-1:0] lvl_q;
	logic          hit_q, pop_q;
	logic [2:0]    stat_q;
	logic [PB-1:0] pp_q;
	logic [IB-1:0] pid_q;
	logic [1:0]    fix_q;
	logic [PB-1:0] bprice_q;
	logic [IB-1:0] bhead_q;
	logic          bany_q;

	// Best-level tournament nodes, one row per tree level
	logic          bt_v [VB+1][NL];
	logic [PB-1:0] bt_p [VB+1][NL];
	logic [VB-1:0] bt_i [VB+1][NL];

	// Level search: match on price, free slot, best level
	logic [PB-1:0] key;
	logic          m_hit, f_hit, b_any;
	logic [VB-1:0] m_idx, f_idx, b_idx;
	always_comb begin
		key   = (st_q == ptob_pkg::B_EXEC || st_q == ptob_pkg::B_WAIT)
			? ((j_q.cmd == ptob_pkg::CMD_INSERT) ? j_q.price : o_rdata[OW-1 -: PB])
			: j_q.price;
		m_hit = 1'b0; m_idx = '0;
		f_hit = 1'b0; f_idx = '0;
		for (int i = NL - 1; i >= 0; i--) begin
			if (lvalid_q[i] && lprice_q[i] == key) begin
				m_hit = 1'b1; m_idx = VB'(i);
			end
			if (!lvalid_q[i]) begin
				f_hit = 1'b1; f_idx = VB'(i);
			end
		end
		// Pick the best level with a compare tree; the lower index wins a tie
		for (int s = 0; s <= VB; s++) begin
			for (int i = 0; i < NL; i++) begin
				bt_v[s][i] = 1'b0;
				bt_p[s][i] = '0;
				bt_i[s][i] = '0;
			end
		end
		for (int i = 0; i < NL; i++) begin
			bt_v[0][i] = lvalid_q[i];
			bt_p[0][i] = lprice_q[i];
			bt_i[0][i] = VB'(i);
		end
		for (int s = 0; s < VB; s++) begin
			for (int i = 0; i < (NL >> (s + 1)); i++) begin
				if (bt_v[s][2*i+1] && (!bt_v[s][2*i] ||
				    (book_side ? bt_p[s][2*i+1] < bt_p[s][2*i]
				               : bt_p[s][2*i+1] > bt_p[s][2*i]))) begin
					bt_v[s+1][i] = 1'b1;
					bt_p[s+1][i] = bt_p[s][2*i+1];
					bt_i[s+1][i] = bt_i[s][2*i+1];
				end else begin
					bt_v[s+1][i] = bt_v[s][2*i];
					bt_p[s+1][i] = bt_p[s][2*i];
					bt_i[s+1][i] = bt_i[s][2*i];
				end
			end
		end
		b_any = bt_v[VB][0];
		b_idx = bt_i[VB][0];
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ptob_pkg::B_IDLE: if (job_valid) st_d = ptob_pkg::B_READ;
			ptob_pkg::B_READ: st_d = ptob_pkg::B_WAIT;
			ptob_pkg::B_WAIT: st_d = ptob_pkg::B_EXEC;
			ptob_pkg::B_EXEC: st_d = ptob_pkg::B_FIX;
			ptob_pkg::B_FIX:  if (fix_q == 2'd0) st_d = ptob_pkg::B_DONE;
			ptob_pkg::B_DONE: st_d = ptob_pkg::B_IDLE;
			default:          st_d = ptob_pkg::B_IDLE;
		endcase
	end

	// Outputs and RAM port
	always_comb begin
		job_take  = (st_q == ptob_pkg::B_IDLE) && job_valid;
		res_valid = (st_q == ptob_pkg::B_DONE);
		res.status        = stat_q;
		res.best_price    = pop_q ? pp_q : (bany_q ? bprice_q : '0);
		res.best_order_id = pop_q ? 8'(pid_q) : (bany_q ? 8'(bhead_q) : 8'd0);
		res.book_empty    = !bany_q;
		o_raddr = tgt_q;
		// pop and peek read the head row of the best level
		if (st_q == ptob_pkg::B_READ &&
		    j_q.cmd inside {ptob_pkg::CMD_POP, ptob_pkg::CMD_PEEK})
			o_raddr = lhead_q[b_idx];
		o_we    = 1'b0;
		o_waddr = tgt_q;
		o_wdata = o_rdata;
		if (st_q == ptob_pkg::B_FIX) begin
			// fix 2: patch prev's next, fix 1: patch next's prev, fix 3: insert write
			case (fix_q)
				2'd3: begin
					o_we    = 1'b1;
					o_waddr = j_q.id;
					o_wdata = {j_q.price, prv_q, NONE};
				end
				2'd2: begin
					o_we    = !prv_q[LB-1];
					o_waddr = prv_q[IB-1:0];
					o_wdata = {o_rdata[OW-1 -: PB], o_rdata[2*LB-1 -: LB], nxt_q};
				end
				2'd1: begin
					o_we    = !nxt_q[LB-1];
					o_waddr = nxt_q[IB-1:0];
					o_wdata = {o_rdata[OW-1 -: PB], prv_q, o_rdata[LB-1:0]};
				end
				default: o_we = 1'b0;
			endcase
			if (fix_q == 2'd2) o_raddr = nxt_q[IB-1:0];
		end
		if (st_q == ptob_pkg::B_EXEC && !prv_q[LB-1]) o_raddr = prv_q[IB-1:0];
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ptob_pkg::B_IDLE;
			ovalid_q <= '0;
			lvalid_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ptob_pkg::B_EXEC && stat_q == 3'(ptob_pkg::ST_OK)) begin
				if (j_q.cmd == ptob_pkg::CMD_INSERT) begin
					ovalid_q[j_q.id] <= 1'b1;
					if (!m_hit) lvalid_q[f_idx] <= 1'b1;
				end else if (hit_q) begin
					ovalid_q[tgt_q] <= 1'b0;
					if (prv_q[LB-1] && o_rdata[LB-1]) lvalid_q[lvl_q] <= 1'b0;
				end
			end
		end
	end

	// Job execution datapath
	always_ff @(posedge clk) begin
		case (st_q)
			ptob_pkg::B_IDLE: if (job_valid) begin
				j_q    <= job;
				tgt_q  <= job.id;
				pop_q  <= 1'b0;
				fix_q  <= 2'd0;
				stat_q <= 3'(ptob_pkg::ST_OK);
			end
			ptob_pkg::B_READ: begin
				// choose the target and early status
				case (j_q.cmd)
					ptob_pkg::CMD_INSERT: begin
						if (ovalid_q[j_q.id]) stat_q <= 3'(ptob_pkg::ST_INUSE);
						else if (!m_hit && !f_hit) stat_q <= 3'(ptob_pkg::ST_FULL);
						hit_q <= m_hit;
						lvl_q <= m_hit ? m_idx : f_idx;
						tgt_q <= m_hit ? ltail_q[m_idx] : j_q.id;
					end
					ptob_pkg::CMD_CANCEL: begin
						if (!ovalid_q[j_q.id]) stat_q <= 3'(ptob_pkg::ST_UNKNOWN);
						hit_q <= 1'b1;
					end
					default: begin
						if (!b_any) stat_q <= 3'(ptob_pkg::ST_EMPTY);
						tgt_q <= lhead_q[b_idx];
						lvl_q <= b_idx;
						hit_q <= (j_q.cmd == ptob_pkg::CMD_POP);
						pop_q <= (j_q.cmd == ptob_pkg::CMD_POP) && b_any;
						pp_q  <= lprice_q[b_idx];
						pid_q <= lhead_q[b_idx];
					end
				endcase
			end
			ptob_pkg::B_WAIT: begin
				// target row is ready; latch its links
				if (j_q.cmd == ptob_pkg::CMD_INSERT) begin
					prv_q <= hit_q ? {1'b0, tgt_q} : NONE;
				end else begin
					prv_q <= o_rdata[2*LB-1 -: LB];
					nxt_q <= o_rdata[LB-1:0];
					if (j_q.cmd == ptob_pkg::CMD_CANCEL) begin
						if (!m_hit && stat_q == 3'(ptob_pkg::ST_OK))
							stat_q <= 3'(ptob_pkg::ST_UNKNOWN);
						lvl_q <= m_idx;
					end
				end
			end
			ptob_pkg::B_EXEC: begin
				nxt_q <= (j_q.cmd == ptob_pkg::CMD_INSERT) ? {1'b0, j_q.id} : nxt_q;
				if (stat_q == 3'(ptob_pkg::ST_OK) && hit_q) begin
					if (j_q.cmd == ptob_pkg::CMD_INSERT) begin
						ltail_q[lvl_q] <= j_q.id;
						fix_q <= 2'd2;
						// reuse next-patch path: write prev(tail).next = id
						prv_q <= {1'b0, tgt_q};
					end else begin
						if (prv_q[LB-1]) lhead_q[lvl_q] <= nxt_q[IB-1:0];
						if (nxt_q[LB-1]) ltail_q[lvl_q] <= prv_q[IB-1:0];
						fix_q <= 2'd2;
					end
				end else if (stat_q == 3'(ptob_pkg::ST_OK) &&
				             j_q.cmd == ptob_pkg::CMD_INSERT) begin
					lprice_q[lvl_q] <= j_q.price;
					lhead_q[lvl_q]  <= j_q.id;
					ltail_q[lvl_q]  <= j_q.id;
					fix_q <= 2'd3;
				end
			end
			ptob_pkg::B_FIX: begin
				if (j_q.cmd == ptob_pkg::CMD_INSERT && fix_q == 2'd2) begin
					fix_q <= 2'd3;
					prv_q <= {1'b0, tgt_q};
				end else if (fix_q == 2'd3) fix_q <= 2'd0;
				else if (fix_q != 2'd0) fix_q <= fix_q - 2'd1;
				bany_q   <= b_any;
				bprice_q <= lprice_q[b_idx];
				bhead_q  <= lhead_q[b_idx];
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/price_time_order_book.sv]
// Price-time order book, one side. Each command passes the back end's read, wait,
// execute, fix and done states; in fix the order link RAM gets its read-modify-write
// sequence, which peek and rejected commands skip. The back end holds one command in
// flight and takes the next only after its result; a two-word queue lets the front
// accept while the back works. Results show for one cycle on result_valid; the
// receiver cannot stall. Async reset empties the book and sets the buy side.
`default_nettype none
`include "assert_macros.svh"
module price_time_order_book (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                start,
	input  wire ptob_pkg::in_word_t  in_word,
	output logic                     busy,
	output logic                     result_valid,
	output ptob_pkg::out_word_t      result
);
	logic           side_q;
	logic           jv, jt;
	ptob_pkg::job_t jb;
	logic           empty_res;

	// Hold the side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_q <= 1'b0;
		else if (cfg_we) side_q <= cfg_wdata;
	end

	ptob_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word), .busy(busy),
		.job_valid(jv), .job(jb), .job_take(jt)
	);

	ptob_back u_back (
		.clk(clk), .arst_n(arst_n), .book_side(side_q), .job_valid(jv), .job(jb),
		.job_take(jt), .res_valid(result_valid), .res(result)
	);

	// Flag a result that reports an empty book with a status other than OK
	assign empty_res = result_valid && result.book_empty &&
		(result.status != 3'(ptob_pkg::ST_OK));

	`ASSERT_IMPLIES(a_take_valid, clk, arst_n, jt, jv)
	`ASSERT_NEXT(a_res_single, clk, arst_n, result_valid, !result_valid)
	`ASSERT_IMPLIES(a_empty_zero, clk, arst_n, empty_res, result.best_price == 16'd0)
endmodule
`default_nettype wire

[bench/price_time_order_book_test.sv]
// Testbench for the one-sided price-time order book.
// Predicts every result word from its own book model; depends on ptob_pkg and the RTL.
`timescale 1ns / 100ps
module price_time_order_book_test;
	localparam int NSLOT = 256;
	localparam int NLVL = 64;
	localparam int NONE = 256;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic start = 1'b0;
	ptob_pkg::in_word_t in_word = '0;
	logic busy;
	logic result_valid;
	ptob_pkg::out_word_t result;

	price_time_order_book DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .in_word(in_word), .busy(busy),
		.result_valid(result_valid), .result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Book shadow
	logic side;
	bit ord_live [NSLOT];
	logic [15:0] ord_px [NSLOT];
	int ord_nx [NSLOT];
	int ord_pv [NSLOT];
	bit lvl_live [NLVL];
	logic [15:0] lvl_px [NLVL];
	int lvl_hd [NLVL];
	int lvl_tl [NLVL];

	ptob_pkg::in_word_t pending_words [$];
	ptob_pkg::out_word_t expected_words [$];
	int gap_after [$];
	int errors = 0;
	int mismatches = 0;

	function automatic int find_lvl(logic [15:0] px);
		for (int i = 0; i < NLVL; i++)
			if (lvl_live[i] && lvl_px[i] == px) return i;
		return NLVL;
	endfunction

	function automatic int best_lvl();
		int b;
		b = NLVL;
		for (int i = 0; i < NLVL; i++) begin
			if (!lvl_live[i]) continue;
			if (b == NLVL) b = i;
			else if (side == 1'b0 ? lvl_px[i] > lvl_px[b] : lvl_px[i] < lvl_px[b]) b = i;
		end
		return b;
	endfunction

	function automatic void unlink(int l, int id);
		int p, n;
		p = ord_pv[id];
		n = ord_nx[id];
		if (p < NONE) ord_nx[p] = n; else lvl_hd[l] = n;
		if (n < NONE) ord_pv[n] = p; else lvl_tl[l] = p;
		ord_live[id] = 0;
		ord_nx[id] = NONE;
		ord_pv[id] = NONE;
		if (lvl_hd[l] >= NONE) lvl_live[l] = 0;
	endfunction

	function automatic ptob_pkg::out_word_t book_step(ptob_pkg::in_word_t w);
		ptob_pkg::out_word_t r;
		ptob_pkg::status_t st;
		int l, b, id, i, t;
		bit popped;
		logic [15:0] ppx;
		logic [7:0] pid;
		st = ptob_pkg::ST_OK;
		popped = 0;
		ppx = '0;
		pid = '0;
		id = w.order_id;
		case (ptob_pkg::cmd_t'(w.command))
			ptob_pkg::CMD_INSERT: begin
				if (ord_live[id]) st = ptob_pkg::ST_INUSE;
				else begin
					l = find_lvl(w.order_price);
					if (l == NLVL) begin
						for (i = 0; i < NLVL; i++) if (!lvl_live[i]) break;
						if (i == NLVL) st = ptob_pkg::ST_FULL;
						else begin
							lvl_live[i] = 1;
							lvl_px[i] = w.order_price;
							lvl_hd[i] = id;
							lvl_tl[i] = id;
							ord_pv[id] = NONE;
						end
					end else begin
						t = lvl_tl[l];
						ord_nx[t] = id;
						ord_pv[id] = t;
						lvl_tl[l] = id;
					end
					if (st == ptob_pkg::ST_OK) begin
						ord_live[id] = 1;
						ord_px[id] = w.order_price;
						ord_nx[id] = NONE;
					end
				end
			end
			ptob_pkg::CMD_CANCEL: begin
				if (!ord_live[id]) st = ptob_pkg::ST_UNKNOWN;
				else begin
					l = find_lvl(ord_px[id]);
					if (l == NLVL) st = ptob_pkg::ST_UNKNOWN; else unlink(l, id);
				end
			end
			default: begin
				b = best_lvl();
				if (b == NLVL) st = ptob_pkg::ST_EMPTY;
				else if (ptob_pkg::cmd_t'(w.command) == ptob_pkg::CMD_POP) begin
					pid = 8'(lvl_hd[b]);
					ppx = lvl_px[b];
					popped = 1;
					unlink(b, lvl_hd[b]);
				end
			end
		endcase
		b = best_lvl();
		r.status = st;
		if (popped) begin
			r.best_price = ppx;
			r.best_order_id = pid;
		end else if (b != NLVL) begin
			r.best_price = lvl_px[b];
			r.best_order_id = 8'(lvl_hd[b]);
		end else begin
			r.best_price = '0;
			r.best_order_id = '0;
		end
		r.book_empty = (b == NLVL);
		return r;
	endfunction

	function automatic int rand_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void push(ptob_pkg::cmd_t c, int id, int px);
		ptob_pkg::in_word_t w;
		w.command = c;
		w.order_id = 8'(id);
		w.order_price = 16'(px);
		pending_words.push_back(w);
		gap_after.push_back(rand_gap());
	endfunction

	// Track acceptance at the rising edge and predict each accepted word
	bit took = 1'b0;
	always @(posedge clk) begin
		took <= arst_n && start && !busy;
		if (arst_n && start && !busy)
			expected_words.push_back(book_step(in_word));
	end

	// Driver: present words at falling edges, hold until accepted
	int hold_cnt = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (took) hold_cnt = gap_after.pop_front();
			if (took) void'(pending_words.pop_front());
			if (start && !took) begin
				// word still waiting: keep it
			end else if (hold_cnt > 0) begin
				hold_cnt = hold_cnt - 1;
				start <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_word <= pending_words[0];
				start <= 1'b1;
			end else start <= 1'b0;
		end
	end

	// Monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin
		ptob_pkg::out_word_t e;
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %h", result);
			end else begin
				e = expected_words.pop_front();
				if (result !== e) begin
					errors++;
					if (mismatches++ < 10)
						$display({"mismatch: expected st=%0d px=%0d id=%0d em=%0d",
							" got st=%0d px=%0d id=%0d em=%0d"},
							e.status, e.best_price, e.best_order_id, e.book_empty,
							result.status, result.best_price, result.best_order_id,
							result.book_empty);
				end
			end
		end
	end

	task automatic wait_drain();
		while (pending_words.size() > 0 || start || expected_words.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_side(logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		side = v;
	endtask

	// Random phase: well-formed order flow over all ids, with prices mostly in a narrow band
	task automatic random_phase(int n);
		int k, px;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 65535);
			else px = 1000 + $urandom_range(0, 40);
			if (k < 45) push(ptob_pkg::CMD_INSERT, $urandom_range(0, 255), px);
			else if (k < 65) push(ptob_pkg::CMD_CANCEL, $urandom_range(0, 255), 0);
			else if (k < 85)
				push(ptob_pkg::CMD_POP, $urandom_range(0, 255), $urandom_range(0, 65535));
			else push(ptob_pkg::CMD_PEEK, $urandom_range(0, 255), $urandom_range(0, 65535));
		end
		wait_drain();
	endtask

	initial begin
		side = 1'b0;
		for (int i = 0; i < NSLOT; i++) begin
			ord_live[i] = 0; ord_nx[i] = NONE; ord_pv[i] = NONE;
		end
		for (int i = 0; i < NLVL; i++) lvl_live[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: empty book, extremes, slot in use, unknown, FIFO order, cancel
		push(ptob_pkg::CMD_POP, 0, 0);
		push(ptob_pkg::CMD_PEEK, 255, 65535);
		push(ptob_pkg::CMD_CANCEL, 7, 0);
		push(ptob_pkg::CMD_INSERT, 0, 0);
		push(ptob_pkg::CMD_INSERT, 255, 65535);
		push(ptob_pkg::CMD_INSERT, 0, 500);
		push(ptob_pkg::CMD_INSERT, 10, 500);
		push(ptob_pkg::CMD_INSERT, 11, 500);
		push(ptob_pkg::CMD_INSERT, 12, 500);
		push(ptob_pkg::CMD_CANCEL, 11, 0);
		push(ptob_pkg::CMD_CANCEL, 10, 0);
		push(ptob_pkg::CMD_CANCEL, 12, 0);
		push(ptob_pkg::CMD_PEEK, 0, 0);
		push(ptob_pkg::CMD_POP, 0, 0);
		push(ptob_pkg::CMD_POP, 0, 0);
		push(ptob_pkg::CMD_POP, 0, 0);
		push(ptob_pkg::CMD_CANCEL, 255, 0);
		wait_drain();

		// Level table full
		for (int i = 0; i < 65; i++) push(ptob_pkg::CMD_INSERT, i, 2000 + i);
		push(ptob_pkg::CMD_INSERT, 100, 2000);
		wait_drain();
		write_side(1'b1);
		push(ptob_pkg::CMD_PEEK, 0, 0);
		push(ptob_pkg::CMD_POP, 0, 0);
		push(ptob_pkg::CMD_INSERT, 200, 9);
		wait_drain();
		for (int i = 0; i < 70; i++) push(ptob_pkg::CMD_POP, 0, 0);
		wait_drain();

		random_phase(450);
		write_side(1'b0);
		random_phase(450);
		write_side(1'b1);
		random_phase(450);
		write_side(1'b0);
		random_phase(450);

		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
